/* hdl/pid_controller_saturated_core_assert.svh */
// assertion macros used by the checker file
`ifndef PID_CONTROLLER_SATURATED_CORE_ASSERT_SVH
`define PID_CONTROLLER_SATURATED_CORE_ASSERT_SVH

// condition holds at every edge outside reset
`define PIDSAT_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define PIDSAT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/pidsat_pkg.sv */
`default_nettype none
package pidsat_pkg;

	localparam int CFG_W   = 24;
	localparam int IDX_W   = 3;
	localparam int DATA_W  = 16;
	localparam int GAIN_W  = 24;
	localparam int ERR_W   = 17;
	localparam int DIFF_W  = 18;
	localparam int DERIV_W = 34;
	localparam int SUM_W   = 48;
	localparam int MUL_A_W = 35;
	localparam int MUL_B_W = 24;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int ACC_W   = 76;
	localparam int STEP_W  = 3;

	// register indexes
	localparam logic [IDX_W-1:0] REG_GAIN_PROP  = 3'd0;
	localparam logic [IDX_W-1:0] REG_GAIN_INTEG = 3'd1;
	localparam logic [IDX_W-1:0] REG_GAIN_DERIV = 3'd2;
	localparam logic [IDX_W-1:0] REG_PERIOD     = 3'd3;
	localparam logic [IDX_W-1:0] REG_RECIP      = 3'd4;
	localparam logic [IDX_W-1:0] REG_SETPOINT   = 3'd5;
	localparam logic [IDX_W-1:0] REG_CLAMP_LOW  = 3'd6;
	localparam logic [IDX_W-1:0] REG_CLAMP_HIGH = 3'd7;

	// multiplier operand selects
	localparam logic [2:0] A_ERR   = 3'd0;
	localparam logic [2:0] A_DIFF  = 3'd1;
	localparam logic [2:0] A_DERIV = 3'd2;
	localparam logic [2:0] A_IH    = 3'd3;
	localparam logic [2:0] A_IL    = 3'd4;

	localparam logic [2:0] B_PERIOD = 3'd0;
	localparam logic [2:0] B_RECIP  = 3'd1;
	localparam logic [2:0] B_GP     = 3'd2;
	localparam logic [2:0] B_GI     = 3'd3;
	localparam logic [2:0] B_GD     = 3'd4;

	// accumulator ops
	localparam logic [1:0] ACC_HOLD  = 2'd0;
	localparam logic [1:0] ACC_CLR   = 2'd1;
	localparam logic [1:0] ACC_ADD16 = 2'd2;
	localparam logic [1:0] ACC_ADD0  = 2'd3;

	// sequencing
	localparam logic SEQ_NEXT = 1'b0;
	localparam logic SEQ_END  = 1'b1;

	typedef struct packed {
		logic [2:0] a_sel;
		logic [2:0] b_sel;
		logic [1:0] acc_op;
		logic       wr_sum;
		logic       wr_deriv;
		logic       seq_op;
	} ctrl_word_t;

	// microprogram: product issued in one step is consumed in the next
	function automatic ctrl_word_t ucode(input logic [STEP_W-1:0] step);
		ctrl_word_t cw;
		cw = '{a_sel: A_ERR, b_sel: B_PERIOD, acc_op: ACC_HOLD,
			wr_sum: 1'b0, wr_deriv: 1'b0, seq_op: SEQ_NEXT};
		case (step)
			3'd0: begin
				cw.a_sel = A_ERR;   cw.b_sel = B_PERIOD; cw.acc_op = ACC_CLR;
			end
			3'd1: begin
				cw.a_sel = A_DIFF;  cw.b_sel = B_RECIP;  cw.wr_sum = 1'b1;
			end
			3'd2: begin
				cw.a_sel = A_ERR;   cw.b_sel = B_GP;     cw.wr_deriv = 1'b1;
			end
			3'd3: begin
				cw.a_sel = A_DERIV; cw.b_sel = B_GD;     cw.acc_op = ACC_ADD16;
			end
			3'd4: begin
				cw.a_sel = A_IH;    cw.b_sel = B_GI;     cw.acc_op = ACC_ADD16;
			end
			3'd5: begin
				cw.a_sel = A_IL;    cw.b_sel = B_GI;     cw.acc_op = ACC_ADD16;
			end
			3'd6: begin
				cw.acc_op = ACC_ADD0;
			end
			3'd7: begin
				cw.seq_op = SEQ_END;
			end
			default: begin
				cw.seq_op = SEQ_END;
			end
		endcase
		return cw;
	endfunction

endpackage
`default_nettype wire

/* hdl/pid_controller_saturated_core.sv */
// each request runs the 8-step microprogram in order, step 0 through step 7,
// and the microprogram shares one 35x24 multiplier; the result register loads in the last step,
// and the last step holds while the result register is full
// a new request is taken in the last step of the previous one
// reset (async, active low): registers to defaults, integral and last error to zero
`default_nettype none
module pid_controller_saturated_core (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_wr_en,
	input  wire logic [pidsat_pkg::IDX_W-1:0]   cfg_index,
	input  wire logic [pidsat_pkg::CFG_W-1:0]   cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic signed [pidsat_pkg::DATA_W-1:0] feedback,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic signed [pidsat_pkg::DATA_W-1:0] drive,
	output logic                                clamped
);
	import pidsat_pkg::*;

	logic signed [GAIN_W-1:0] gain_prop_q, gain_integ_q, gain_deriv_q;
	logic [DATA_W-1:0]        period_q, recip_q;
	logic signed [DATA_W-1:0] setpoint_q, clamp_low_q, clamp_high_q;

	logic signed [DATA_W-1:0] fb_q;
	logic signed [SUM_W-1:0]  error_sum_q;
	logic signed [ERR_W-1:0]  last_error_q;
	logic signed [DERIV_W-1:0] deriv_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic                     busy_q;
	logic [STEP_W-1:0]        step_q;
	logic                     out_valid_q;
	logic signed [DATA_W-1:0] drive_q;
	logic                     clamped_q;

	ctrl_word_t               cw;
	logic signed [ERR_W-1:0]  err_w;
	logic signed [DIFF_W-1:0] diff_w;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0] prod_w;
	logic signed [SUM_W:0]    sum_ext;
	logic signed [SUM_W-1:0]  sum_sat;
	logic signed [ACC_W-ACC_W+SUM_W-1:0] val_w;
	logic signed [SUM_W-1:0]  lim_high, lim_low;
	logic signed [DATA_W-1:0] drive_w;
	logic                     clamped_w;
	logic                     out_free, fin_w, in_acc;

	assign cw = ucode(step_q);

	assign err_w  = ERR_W'(setpoint_q) - ERR_W'(fb_q);
	assign diff_w = DIFF_W'(err_w) - DIFF_W'(last_error_q);

	always_comb begin
		case (cw.a_sel)
			A_ERR:   mul_a = MUL_A_W'(err_w);
			A_DIFF:  mul_a = MUL_A_W'(diff_w);
			A_DERIV: mul_a = MUL_A_W'(deriv_q);
			A_IH:    mul_a = MUL_A_W'($signed(error_sum_q[SUM_W-1:16]));
			A_IL:    mul_a = $signed({{(MUL_A_W-16){1'b0}}, error_sum_q[15:0]});
			default: mul_a = '0;
		endcase
		case (cw.b_sel)
			B_PERIOD: mul_b = $signed({{(MUL_B_W-DATA_W){1'b0}}, period_q});
			B_RECIP:  mul_b = $signed({{(MUL_B_W-DATA_W){1'b0}}, recip_q});
			B_GP:     mul_b = gain_prop_q;
			B_GI:     mul_b = gain_integ_q;
			B_GD:     mul_b = gain_deriv_q;
			default:  mul_b = '0;
		endcase
	end

	assign prod_w = mul_a * mul_b;

	// integral update with saturation at the 48-bit range
	always_comb begin
		sum_ext = (SUM_W+1)'(error_sum_q) +
			(SUM_W+1)'($signed(prod_q[ERR_W+DATA_W-1:0]));
		if (sum_ext[SUM_W] != sum_ext[SUM_W-1])
			sum_sat = sum_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		else
			sum_sat = sum_ext[SUM_W-1:0];
	end

	// acc holds the Q.28 total, truncate toward zero then clamp, high test first
	always_comb begin
		val_w = acc_q[ACC_W-1:28];
		if (acc_q[ACC_W-1] && (|acc_q[27:0]))
			val_w = val_w + SUM_W'(1);
		lim_high  = SUM_W'(clamp_high_q);
		lim_low   = SUM_W'(clamp_low_q);
		clamped_w = 1'b1;
		if (val_w > lim_high)
			drive_w = clamp_high_q;
		else if (val_w < lim_low)
			drive_w = clamp_low_q;
		else begin
			drive_w   = val_w[DATA_W-1:0];
			clamped_w = 1'b0;
		end
	end

	assign out_free = !out_valid_q || out_ready;
	assign fin_w    = busy_q && (cw.seq_op == SEQ_END) && out_free;
	assign in_ready = !busy_q || fin_w;
	assign in_acc   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_prop_q  <= '0;
			gain_integ_q <= '0;
			gain_deriv_q <= '0;
			period_q     <= '1;
			recip_q      <= DATA_W'(1);
			setpoint_q   <= '0;
			clamp_low_q  <= {1'b1, {(DATA_W-1){1'b0}}};
			clamp_high_q <= {1'b0, {(DATA_W-1){1'b1}}};
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_GAIN_PROP:  gain_prop_q  <= cfg_data;
				REG_GAIN_INTEG: gain_integ_q <= cfg_data;
				REG_GAIN_DERIV: gain_deriv_q <= cfg_data;
				REG_PERIOD:     period_q     <= cfg_data[DATA_W-1:0];
				REG_RECIP:      recip_q      <= cfg_data[DATA_W-1:0];
				REG_SETPOINT:   setpoint_q   <= cfg_data[DATA_W-1:0];
				REG_CLAMP_LOW:  clamp_low_q  <= cfg_data[DATA_W-1:0];
				REG_CLAMP_HIGH: clamp_high_q <= cfg_data[DATA_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (in_acc) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			if (cw.seq_op == SEQ_NEXT)
				step_q <= step_q + STEP_W'(1);
			else if (fin_w)
				busy_q <= 1'b0;
		end
	end

	// datapath state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_sum_q  <= '0;
			last_error_q <= '0;
		end else begin
			if (busy_q && cw.wr_sum)
				error_sum_q <= sum_sat;
			if (fin_w)
				last_error_q <= err_w;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc)
			fb_q <= feedback;
		prod_q <= prod_w;
		if (busy_q && cw.wr_deriv)
			deriv_q <= prod_q[DERIV_W-1:0];
		if (busy_q) begin
			case (cw.acc_op)
				ACC_CLR:   acc_q <= '0;
				ACC_ADD16: acc_q <= acc_q + $signed({prod_q[PROD_W-1], prod_q, 16'b0});
				ACC_ADD0:  acc_q <= acc_q + ACC_W'(prod_q);
				default:   acc_q <= acc_q;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (fin_w)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (fin_w) begin
			drive_q   <= drive_w;
			clamped_q <= clamped_w;
		end
	end

	assign out_valid = out_valid_q;
	assign drive     = drive_q;
	assign clamped   = clamped_q;

endmodule
`default_nettype wire

/* hdl/pidsat_checker.sv */
`default_nettype none
`include "pid_controller_saturated_core_assert.svh"
module pidsat_checker (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_wr_en,
	input  wire logic [pidsat_pkg::IDX_W-1:0]         cfg_index,
	input  wire logic [pidsat_pkg::CFG_W-1:0]         cfg_data,
	input  wire logic                                 in_valid,
	input  wire logic                                 in_ready,
	input  wire logic signed [pidsat_pkg::DATA_W-1:0] feedback,
	input  wire logic                                 out_valid,
	input  wire logic                                 out_ready,
	input  wire logic signed [pidsat_pkg::DATA_W-1:0] drive,
	input  wire logic                                 clamped
);
	import pidsat_pkg::*;

	logic [1:0] pending_q;
	logic       in_acc, out_acc;
	logic       cfg_seen;

	assign in_acc   = in_valid && in_ready;
	assign out_acc  = out_valid && out_ready;
	assign cfg_seen = cfg_wr_en && (cfg_index <= REG_CLAMP_HIGH) && (|cfg_data || !(|feedback));

	// requests taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pending_q <= '0;
		else if (in_acc && !out_acc)
			pending_q <= pending_q + 2'd1;
		else if (out_acc && !in_acc)
			pending_q <= pending_q - 2'd1;
	end

	`PIDSAT_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(drive) && $stable(clamped) && (cfg_seen || !cfg_seen),
		"result dropped or changed while stalled")
	`PIDSAT_ASSERT_ALWAYS(a_no_spurious, clk, arst_n, !out_valid || (pending_q != 2'd0),
		"result without a request")
	`PIDSAT_ASSERT_ALWAYS(a_pending_max, clk, arst_n, pending_q <= 2'd2,
		"more than two requests in flight")
	`PIDSAT_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_acc, !in_ready,
		"request taken while sequencer busy")

endmodule

bind pid_controller_saturated_core pidsat_checker u_pidsat_checker (.*);
`default_nettype wire
